>>> src/lts_pkg.sv
// Shared constants, types and a helper function for the LRU tag store.
`timescale 1ns / 1ps

package lts_pkg;

  // Table geometry
  localparam int NUM_SLOTS   = 64;
  localparam int IDX_W       = $clog2(NUM_SLOTS);
  localparam int TREE_LEAVES = 1 << IDX_W;
  localparam int TREE_LEVELS = IDX_W;
  localparam int CNT_W       = $clog2(TREE_LEVELS + 1);

  // Field widths
  localparam int REQ_W      = 3;
  localparam int KEY_W      = 64;
  localparam int HANDLE_W   = 32;
  localparam int TIME_W     = 32;
  localparam int SLOT_IDX_W = 6;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_GET     = 3'd0,
    REQ_PEEK    = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_RELEASE = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_VICTIM,
    ST_READ,
    ST_COMMIT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic lookup;
    logic read;
    logic commit;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_insert;
    logic victim_ok;
  } dp_sts_t;

  // Index of the lowest set bit; isolate it with one add, then OR-encode.
  function automatic logic [IDX_W-1:0] first_set(input logic [NUM_SLOTS-1:0] vec);
    logic [NUM_SLOTS-1:0] oh;
    logic [IDX_W-1:0]     idx;
    oh  = vec & (~vec + NUM_SLOTS'(1));
    idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> src/lts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lts_datapath.sv
// Datapath: key cells, valid bits, timestamp min-tree, handle RAM and result register.
`timescale 1ns / 1ps

module lts_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lts_pkg::ctrl_cmd_t             cmd_i,
  output lts_pkg::dp_sts_t               sts_o,
  input  logic [lts_pkg::REQ_W-1:0]      req_type_i,
  input  logic [lts_pkg::KEY_W-1:0]      key_i,
  input  logic [lts_pkg::HANDLE_W-1:0]   handle_i,
  input  logic [lts_pkg::TIME_W-1:0]     now_i,
  output logic                           hit_o,
  output logic [lts_pkg::HANDLE_W-1:0]   found_handle_o,
  output logic [lts_pkg::SLOT_IDX_W-1:0] slot_index_o,
  output logic [lts_pkg::HANDLE_W-1:0]   displaced_handle_o
);

  import lts_pkg::*;

  // Latched request
  logic [REQ_W-1:0]    req_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [TIME_W-1:0]   now_q;

  // Slot state
  logic [NUM_SLOTS-1:0] valid_q;
  logic [KEY_W-1:0]     key_cells_q [NUM_SLOTS];
  logic [TIME_W-1:0]    time_q      [NUM_SLOTS];

  // Lookup results
  logic [NUM_SLOTS-1:0] match;
  logic                 match_hit_q;
  logic [IDX_W-1:0]     match_idx_q;
  logic                 free_hit_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [IDX_W-1:0]     target_d, target_q;

  // Min-tree, heap layout: nodes 1..LEAVES-1 registered, leaves above
  logic [TIME_W-1:0] all_time [1:2*TREE_LEAVES-1];
  logic [IDX_W-1:0]  all_idx  [1:2*TREE_LEAVES-1];
  logic [TIME_W-1:0] node_time_q [1:TREE_LEAVES-1];
  logic [IDX_W-1:0]  node_idx_q  [1:TREE_LEAVES-1];
  logic [CNT_W-1:0]  settle_cnt_q;
  logic              tree_ready;

  // Commit decode
  logic [HANDLE_W-1:0]   ram_rdata;
  logic [HANDLE_W-1:0]   held;
  logic                  res_hit;
  logic [HANDLE_W-1:0]   res_found;
  logic [SLOT_IDX_W-1:0] res_idx;
  logic [HANDLE_W-1:0]   res_disp;
  logic                  wr_time, wr_entry, clr_valid, clear_all;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q    <= req_type_i;
      key_q    <= key_i;
      handle_q <= handle_i;
      now_q    <= now_i;
    end
  end

  // Parallel key compare, one lane per slot
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = valid_q[i] && (key_cells_q[i] == key_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      match_hit_q <= |match;
      match_idx_q <= first_set(match);
      free_hit_q  <= ~&valid_q;
      free_idx_q  <= first_set(~valid_q);
    end
  end

  // Tree leaves; padding leaves carry the largest time and never win
  for (genvar l = 0; l < TREE_LEAVES; l++) begin : g_leaf
    if (l < NUM_SLOTS) begin : g_real
      assign all_time[TREE_LEAVES+l] = time_q[l];
    end else begin : g_pad
      assign all_time[TREE_LEAVES+l] = '1;
    end
    assign all_idx[TREE_LEAVES+l] = IDX_W'(l);
  end

  for (genvar n = 1; n < TREE_LEAVES; n++) begin : g_node
    assign all_time[n] = node_time_q[n];
    assign all_idx[n]  = node_idx_q[n];
  end

  // One compare per node per cycle; left (lower index) wins ties
  always_ff @(posedge clk_i) begin
    for (int n = 1; n < TREE_LEAVES; n++) begin
      if (all_time[2*n+1] < all_time[2*n]) begin
        node_time_q[n] <= all_time[2*n+1];
        node_idx_q[n]  <= all_idx[2*n+1];
      end else begin
        node_time_q[n] <= all_time[2*n];
        node_idx_q[n]  <= all_idx[2*n];
      end
    end
  end

  // Root is valid once every level has seen the latest timestamps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_cnt_q <= '0;
    end else if (cmd_i.commit && wr_time) begin
      settle_cnt_q <= '0;
    end else if (settle_cnt_q != CNT_W'(TREE_LEVELS)) begin
      settle_cnt_q <= settle_cnt_q + CNT_W'(1);
    end
  end

  assign tree_ready = (settle_cnt_q == CNT_W'(TREE_LEVELS));

  // Target slot: lookup match, or lowest free, or oldest
  always_comb begin
    if (req_q == REQ_INSERT) begin
      target_d = free_hit_q ? free_idx_q : all_idx[1];
    end else begin
      target_d = match_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      target_q <= target_d;
    end
  end

  assign sts_o.is_insert = (req_q == REQ_INSERT);
  assign sts_o.victim_ok = free_hit_q || tree_ready;

  // Handle storage
  lts_ram #(
    .WIDTH(HANDLE_W),
    .DEPTH(NUM_SLOTS)
  ) u_handle_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit && wr_entry),
    .waddr_i(target_q),
    .wdata_i(handle_q),
    .re_i   (cmd_i.read),
    .raddr_i(target_d),
    .rdata_o(ram_rdata)
  );

  // An empty slot reads as handle zero
  assign held = valid_q[target_q] ? ram_rdata : '0;

  // Result and update decode
  always_comb begin
    res_hit   = 1'b0;
    res_found = '0;
    res_idx   = '0;
    res_disp  = '0;
    wr_time   = 1'b0;
    wr_entry  = 1'b0;
    clr_valid = 1'b0;
    clear_all = 1'b0;
    case (req_q)
      REQ_GET, REQ_PEEK, REQ_RELEASE: begin
        if (match_hit_q) begin
          res_hit   = 1'b1;
          res_found = held;
          res_idx   = SLOT_IDX_W'(target_q);
          if (req_q == REQ_GET) begin
            wr_time = 1'b1;
          end
          if (req_q == REQ_RELEASE) begin
            res_disp  = held;
            clr_valid = 1'b1;
          end
        end
      end
      REQ_INSERT: begin
        if (handle_q != '0) begin
          res_idx  = SLOT_IDX_W'(target_q);
          res_disp = held;
          wr_time  = 1'b1;
          wr_entry = 1'b1;
        end
      end
      REQ_CLEAR: begin
        clear_all = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      if (clear_all) begin
        valid_q <= '0;
      end else if (wr_entry) begin
        valid_q[target_q] <= 1'b1;
      end else if (clr_valid) begin
        valid_q[target_q] <= 1'b0;
      end
    end
  end

  // Key cells and timestamps
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_entry) begin
      key_cells_q[target_q] <= key_q;
    end
    if (cmd_i.commit && wr_time) begin
      time_q[target_q] <= now_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o              <= res_hit;
      found_handle_o     <= res_found;
      slot_index_o       <= res_idx;
      displaced_handle_o <= res_disp;
    end
  end

endmodule

>>> src/lts_ctrl.sv
// Controller: request sequencing state machine and result valid flag.
`timescale 1ns / 1ps

module lts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  lts_pkg::dp_sts_t   sts_i,
  output lts_pkg::ctrl_cmd_t cmd_o
);

  import lts_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new result
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = sts_i.is_insert ? ST_VICTIM : ST_READ;
      end
      ST_VICTIM: begin
        if (sts_i.victim_ok) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/lru_tag_store.sv
// Top level of the LRU tag store: controller plus datapath.
`timescale 1ns / 1ps

// Fully associative table of NUM_SLOTS (64) slots, each with a 64-bit key,
// a nonzero handle and a last-use timestamp. Requests are get (lookup and
// refresh timestamp), peek, insert (lowest free slot, else the oldest, lowest
// index on ties), release and clear; every request returns one result. One
// request is in work at a time: accept, parallel key compare, handle RAM read
// and commit follow in order, with a victim step between compare and read for
// an insert. An insert into a full table waits in that step for the
// registered timestamp minimum tree ($clog2(NUM_SLOTS) = 6 levels, one per
// cycle) to settle after the last timestamp write. A new request is
// accepted while the previous result still waits in the output register.
// No clearing pass is needed after reset; the slot valid bits reset at once.
module lru_tag_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lts_pkg::REQ_W-1:0]      req_type_i,
  input  logic [lts_pkg::KEY_W-1:0]      key_i,
  input  logic [lts_pkg::HANDLE_W-1:0]   handle_i,
  input  logic [lts_pkg::TIME_W-1:0]     now_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic [lts_pkg::HANDLE_W-1:0]   found_handle_o,
  output logic [lts_pkg::SLOT_IDX_W-1:0] slot_index_o,
  output logic [lts_pkg::HANDLE_W-1:0]   displaced_handle_o
);

  import lts_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lts_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_type_i        (req_type_i),
    .key_i             (key_i),
    .handle_i          (handle_i),
    .now_i             (now_i),
    .hit_o             (hit_o),
    .found_handle_o    (found_handle_o),
    .slot_index_o      (slot_index_o),
    .displaced_handle_o(displaced_handle_o)
  );

endmodule

>>> src/lts_checker.sv
// Port-level assertions for the LRU tag store, bound to the top level.
`timescale 1ns / 1ps

module lts_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           hit_o,
  input logic [lts_pkg::HANDLE_W-1:0]   found_handle_o,
  input logic [lts_pkg::HANDLE_W-1:0]   displaced_handle_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One request at a time: the cycle after an accept is stalled
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted back to back");

  // A miss never reports a found handle
  a_miss_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> found_handle_o == '0)
    else $error("found handle on a miss");

  // Occupied slots always hold nonzero handles
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> found_handle_o != '0)
    else $error("hit with zero handle");

  // On a hit only a release displaces, and it displaces the found handle
  a_hit_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> (displaced_handle_o == '0) ||
                             (displaced_handle_o == found_handle_o))
    else $error("hit displaced a different handle");

endmodule

bind lru_tag_store lts_checker u_lts_checker (.*);
